// ===== src/motor_duty_cycle_sequencer_top_macros.svh =====
// Assertion macros for the motor duty-cycle sequencer.
`ifndef MOTOR_DUTY_CYCLE_SEQUENCER_TOP_MACROS_SVH
`define MOTOR_DUTY_CYCLE_SEQUENCER_TOP_MACROS_SVH

// Same-cycle implication, off during reset.
`define MDCS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, off during reset.
`define MDCS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/mdcs_pkg.sv =====
// Shared types, constants and helpers of the motor duty-cycle sequencer.
package mdcs_pkg;

  localparam int unsigned TICK_W = 32;
  localparam int unsigned CYC_W  = 10;

  typedef logic [TICK_W-1:0] ticks_t;
  typedef logic [CYC_W-1:0]  cycles_t;

  // Arm command codes; the unused code keeps the flag
  localparam logic [1:0] ARM_KEEP  = 2'd0;
  localparam logic [1:0] ARM_CLEAR = 2'd1;
  localparam logic [1:0] ARM_SET   = 2'd2;

  // Configuration register indexes
  localparam logic [0:0] REG_ON_TIME  = 1'b0;
  localparam logic [0:0] REG_OFF_TIME = 1'b1;

  // Reset values
  localparam ticks_t  RESET_ON_TIME  = 32'd120000;
  localparam ticks_t  RESET_OFF_TIME = 32'd120000;
  localparam cycles_t RESET_CYCLES   = 10'd4;
  localparam ticks_t  TICKS_SAT      = '1;

  typedef struct packed {
    logic       tick;
    logic       start_run;
    cycles_t    run_count;
    logic       stop_run;
    logic       toggle_direction;
    logic [1:0] load_arm_cmd;
    logic [1:0] discharge_arm_cmd;
    logic       load_switch;
    logic       discharge_switch;
  } item_t;

  // Input stage contents handed to the sequencer core
  typedef struct packed {
    logic  valid;
    item_t item;
  } stage_t;

  function automatic logic arm_next(input logic flag, input logic [1:0] cmd);
    logic res;
    res = flag;
    if (cmd == ARM_CLEAR) res = 1'b0;
    else if (cmd == ARM_SET) res = 1'b1;
    return res;
  endfunction

endpackage

// ===== src/mdcs_if.sv =====
// Valid/ready channel interfaces for commands in and status out.
interface mdcs_in_if import mdcs_pkg::*; ();
  logic       valid;
  logic       ready;
  logic       tick;
  logic       start_run;
  cycles_t    run_count;
  logic       stop_run;
  logic       toggle_direction;
  logic [1:0] load_arm_cmd;
  logic [1:0] discharge_arm_cmd;
  logic       load_switch;
  logic       discharge_switch;

  modport source (
    output valid, tick, start_run, run_count, stop_run, toggle_direction,
           load_arm_cmd, discharge_arm_cmd, load_switch, discharge_switch,
    input  ready
  );
  modport sink (
    input  valid, tick, start_run, run_count, stop_run, toggle_direction,
           load_arm_cmd, discharge_arm_cmd, load_switch, discharge_switch,
    output ready
  );
endinterface

interface mdcs_out_if import mdcs_pkg::*; ();
  logic    valid;
  logic    ready;
  logic    motor_on;
  logic    direction;
  logic    cycling;
  cycles_t remaining_cycles;
  ticks_t  elapsed_ticks;
  logic    load_armed;
  logic    discharge_armed;

  modport source (
    output valid, motor_on, direction, cycling, remaining_cycles, elapsed_ticks,
           load_armed, discharge_armed,
    input  ready
  );
  modport sink (
    input  valid, motor_on, direction, cycling, remaining_cycles, elapsed_ticks,
           load_armed, discharge_armed,
    output ready
  );
endinterface

// ===== src/mdcs_in_reg.sv =====
// Input register stage: captures one command beat and holds it for the core.
module mdcs_in_reg import mdcs_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  mdcs_in_if.sink      in_ch,
  input  logic         advance,
  output stage_t       stage
);

  logic  valid_r, valid_nxt;
  item_t item_r;
  logic  load;

  // Take a beat when empty or when the held one moves on
  assign in_ch.ready = !valid_r || advance;
  assign load        = in_ch.valid && in_ch.ready;

  always_comb begin
    valid_nxt = valid_r;
    if (load) valid_nxt = 1'b1;
    else if (advance) valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Hold payload
  always_ff @(posedge clk) begin
    if (load) begin
      item_r.tick              <= in_ch.tick;
      item_r.start_run         <= in_ch.start_run;
      item_r.run_count         <= in_ch.run_count;
      item_r.stop_run          <= in_ch.stop_run;
      item_r.toggle_direction  <= in_ch.toggle_direction;
      item_r.load_arm_cmd      <= in_ch.load_arm_cmd;
      item_r.discharge_arm_cmd <= in_ch.discharge_arm_cmd;
      item_r.load_switch       <= in_ch.load_switch;
      item_r.discharge_switch  <= in_ch.discharge_switch;
    end
  end

  assign stage.valid = valid_r;
  assign stage.item  = item_r;

endmodule

// ===== src/mdcs_seq_core.sv =====
// Sequencer core: state update for one beat and the result register.
module mdcs_seq_core import mdcs_pkg::*; #(
  parameter int unsigned CYCLE_LIMIT = 999
) (
  input  logic         clk,
  input  logic         rst_n,
  input  stage_t       stage,
  input  ticks_t       on_time,
  input  ticks_t       off_time,
  output logic         advance,
  mdcs_out_if.source   out_ch
);

  localparam cycles_t LIMIT = cycles_t'(CYCLE_LIMIT);

  // Sequencer state
  logic    run_r, run_nxt;
  logic    dir_r, dir_nxt;
  cycles_t cur_r, cur_nxt;
  cycles_t max_r, max_nxt;
  ticks_t  ss_r, ss_nxt;
  logic    la_r, la_nxt;
  logic    da_r, da_nxt;

  // Result register
  logic    out_valid_r;
  logic    motor_on_r, direction_r, cycling_r, load_armed_r, discharge_armed_r;
  cycles_t remaining_r;
  ticks_t  elapsed_r;

  logic    inc;
  logic    on_expired;
  logic    off_expired;
  item_t   it;

  assign it      = stage.item;
  assign advance = stage.valid && (!out_valid_r || out_ch.ready);

  // Elapsed count compares run beside the increment
  assign inc         = it.tick && (ss_r != TICKS_SAT);
  assign on_expired  = inc ? (ss_r >= on_time)  : (ss_r > on_time);
  assign off_expired = inc ? (ss_r >= off_time) : (ss_r > off_time);

  // Next state in command order
  always_comb begin
    run_nxt = run_r;
    dir_nxt = dir_r ^ it.toggle_direction;
    cur_nxt = cur_r;
    max_nxt = max_r;
    la_nxt  = la_r;
    da_nxt  = da_r;
    ss_nxt  = inc ? ss_r + 32'd1 : ss_r;

    if (it.start_run) begin
      max_nxt = (it.run_count > 10'd1 && it.run_count < LIMIT) ? it.run_count : LIMIT;
      cur_nxt = 10'd1;
    end
    if (it.stop_run) begin
      run_nxt = 1'b0;
      la_nxt  = 1'b0;
      da_nxt  = 1'b0;
      cur_nxt = max_nxt;
    end
    la_nxt = arm_next(la_nxt, it.load_arm_cmd);
    da_nxt = arm_next(da_nxt, it.discharge_arm_cmd);

    // Timed switches: on-phase timeout, else off-phase restart
    if (run_nxt && on_expired) begin
      run_nxt = 1'b0;
      la_nxt  = 1'b0;
      da_nxt  = 1'b0;
      ss_nxt  = '0;
    end else if (!run_nxt && max_nxt > cur_nxt && off_expired) begin
      cur_nxt = cur_nxt + 10'd1;
      run_nxt = 1'b1;
      ss_nxt  = '0;
    end

    // Armed limit switches
    if (la_nxt && run_nxt && !it.load_switch) begin
      run_nxt = 1'b0;
      la_nxt  = 1'b0;
      da_nxt  = 1'b0;
    end
    if (da_nxt && run_nxt && !it.discharge_switch) begin
      run_nxt = 1'b0;
      la_nxt  = 1'b0;
      da_nxt  = 1'b0;
    end
  end

  // Advance state on each beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r <= 1'b0;
      dir_r <= 1'b0;
      cur_r <= RESET_CYCLES;
      max_r <= RESET_CYCLES;
      ss_r  <= '0;
      la_r  <= 1'b0;
      da_r  <= 1'b0;
    end else if (advance) begin
      run_r <= run_nxt;
      dir_r <= dir_nxt;
      cur_r <= cur_nxt;
      max_r <= max_nxt;
      ss_r  <= ss_nxt;
      la_r  <= la_nxt;
      da_r  <= da_nxt;
    end
  end

  // Result valid: set on a beat, drop once taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (advance) begin
      motor_on_r        <= run_nxt;
      direction_r       <= dir_nxt;
      cycling_r         <= max_nxt > cur_nxt;
      remaining_r       <= max_nxt - cur_nxt;
      elapsed_r         <= ss_nxt;
      load_armed_r      <= la_nxt;
      discharge_armed_r <= da_nxt;
    end
  end

  assign out_ch.valid            = out_valid_r;
  assign out_ch.motor_on         = motor_on_r;
  assign out_ch.direction        = direction_r;
  assign out_ch.cycling          = cycling_r;
  assign out_ch.remaining_cycles = remaining_r;
  assign out_ch.elapsed_ticks    = elapsed_r;
  assign out_ch.load_armed       = load_armed_r;
  assign out_ch.discharge_armed  = discharge_armed_r;

endmodule

// ===== src/motor_duty_cycle_sequencer_top.sv =====
// Top level of the motor duty-cycle sequencer.
//
//  channel | dir | handshake        | beat contents
//  in_ch   | in  | valid / ready    | tick, commands, switch levels
//  out_ch  | out | valid / ready    | motor, direction, run and arming status
//  cfg_*   | in  | cfg_we           | on and off times, indexed by cfg_index
//
// One beat a cycle sustained while out_ch keeps up; a beat's result is offered on
// out_ch once it has passed from the input register into the result register.
// The input register takes a new beat while empty, or while the result register
// frees up; with both full and out_ch stalled, in_ch.ready drops.
// Reset (rst_n low, synchronous) leaves the motor off, run idle at cycle four
// of four, and both times at 120000 ticks.
`include "motor_duty_cycle_sequencer_top_macros.svh"

module motor_duty_cycle_sequencer_top import mdcs_pkg::*; #(
  parameter int unsigned CYCLE_LIMIT = 999
) (
  input  logic        clk,
  input  logic        rst_n,
  mdcs_in_if.sink     in_ch,
  mdcs_out_if.source  out_ch,
  input  logic        cfg_we,
  input  logic [0:0]  cfg_index,
  input  ticks_t      cfg_wdata
);

  ticks_t on_time_r;
  ticks_t off_time_r;
  stage_t stage;
  logic   advance;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      on_time_r  <= RESET_ON_TIME;
      off_time_r <= RESET_OFF_TIME;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ON_TIME:  on_time_r  <= cfg_wdata;
        REG_OFF_TIME: off_time_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  mdcs_in_reg u_in_reg (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .advance (advance),
    .stage   (stage)
  );

  mdcs_seq_core #(
    .CYCLE_LIMIT (CYCLE_LIMIT)
  ) u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .stage    (stage),
    .on_time  (on_time_r),
    .off_time (off_time_r),
    .advance  (advance),
    .out_ch   (out_ch)
  );

  // Checks
  `MDCS_ASSERT_NOW(a_cycling_matches, clk, rst_n, out_ch.valid, out_ch.cycling == (out_ch.remaining_cycles != 10'd0), "cycling disagrees with remaining count")
  `MDCS_ASSERT_NOW(a_remaining_bound, clk, rst_n, out_ch.valid, out_ch.remaining_cycles <= 10'(CYCLE_LIMIT - 1), "remaining count above limit")
  `MDCS_ASSERT_NOW(a_on_within_time, clk, rst_n, out_ch.valid && out_ch.motor_on, out_ch.elapsed_ticks <= on_time_r, "motor on past its on time")
  `MDCS_ASSERT_NEXT(a_beat_reaches_out, clk, rst_n, stage.valid && advance, out_ch.valid, "advanced beat left no result")

endmodule
